// ----- rtl/sfm_pkg.sv -----
// sfm_pkg: types and constants of the substring first-match search block
// used by the core and the testbench; no dependencies

package sfm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_START   = 2'd3;

    localparam int PATTERN_LEN_W  = 5;
    localparam int SEARCH_START_W = 16;
    localparam int MATCH_POS_W    = 16;
    localparam int REG_BYTES      = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [MATCH_POS_W-1:0] match_position;
    } out_item_t;

endpackage

// ----- rtl/sfm_stream_if.sv -----
// sfm_stream_if: valid/ready stream channel with a typed payload
// payload types come from sfm_pkg

interface sfm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/substring_first_match_core.sv -----
// substring_first_match_core: streaming exact search for the first match of a pattern
// depends on sfm_pkg and sfm_stream_if

// Usage
//   data   : sink channel, one view byte per transfer (data_byte, last_byte marks view end)
//   result : source channel, at most one transfer per view: found = 1 with the position
//            of the first pattern byte, or found = 0 and position 0 on the last byte
//   cfg_*  : write port for pattern_low, pattern_high, pattern_length, search_start;
//            write only while no byte is in flight
// Timing
//   a byte taken into the input register is compared there and, when it moves on, loads
//   the result register; throughput is one byte per cycle while no result stalls, set by
//   the single window compare between the input register and the result register
//   after the last byte the window, position and match flag return to their reset state
// Reset
//   rst_n clears all control state and restores the register defaults
// Stalls
//   while a result waits and result.ready is low, the pending byte holds in the input
//   register and data.ready drops; nothing is lost or repeated

module substring_first_match_core #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [sfm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sfm_pkg::CFG_DATA_W-1:0]   cfg_write_data,
    sfm_stream_if.sink                       data,
    sfm_stream_if.source                     result
);
    import sfm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int POS_W = POSITION_BITS + 1;
    localparam int CMP_W = (POS_W > SEARCH_START_W) ? POS_W : SEARCH_START_W;
    localparam logic [POS_W-1:0] POS_SAT =
        {1'b1, {POSITION_BITS{1'b0}}} + POS_W'(MAX_PATTERN);

    // configuration registers
    logic [CFG_DATA_W-1:0]     pattern_low_reg;
    logic [CFG_DATA_W-1:0]     pattern_high_reg;
    logic [PATTERN_LEN_W-1:0]  pattern_length_reg;
    logic [SEARCH_START_W-1:0] search_start_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] data_byte_reg;
    logic       last_byte_reg;

    // view state
    logic [7:0]       window_reg [MAX_PATTERN];
    logic [7:0]       window_next [MAX_PATTERN];
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic             reported_reg;
    logic             reported_next;

    // result register
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [MATCH_POS_W-1:0] match_position_reg;

    logic [7:0]       pattern_bytes [MAX_PATTERN];
    logic [LEN_W-1:0] active_len;
    logic [LEN_W-1:0] pidx;
    logic             bytes_equal;
    logic [POS_W-1:0] begin_pos;
    logic [CMP_W-1:0] begin_ext;
    logic [CMP_W-1:0] start_ext;
    logic             hit;
    logic             emit_hit;
    logic             emit_miss;
    logic             fire;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= PATTERN_LEN_W'(1);
            search_start_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_write_data;
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_write_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_write_data[PATTERN_LEN_W-1:0];
                CFG_SEARCH_START:   search_start_reg   <= cfg_write_data[SEARCH_START_W-1:0];
            endcase
        end
    end

    // pattern byte table, zero past the two registers
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_pat
        if (k < REG_BYTES)
        begin : g_low
            assign pattern_bytes[k] = pattern_low_reg[8*k +: 8];
        end
        else if (k < 2 * REG_BYTES)
        begin : g_high
            assign pattern_bytes[k] = pattern_high_reg[8*(k-REG_BYTES) +: 8];
        end
        else
        begin : g_zero
            assign pattern_bytes[k] = 8'd0;
        end
    end

    // shifted window, newest byte at index 0
    assign window_next[0] = data_byte_reg;
    for (genvar j = 1; j < MAX_PATTERN; j++)
    begin : g_shift
        assign window_next[j] = window_reg[j-1];
    end

    always_comb
    begin
        priority if (pattern_length_reg == '0)
            active_len = LEN_W'(1);
        else if ({1'b0, pattern_length_reg} > (PATTERN_LEN_W+1)'(MAX_PATTERN))
            active_len = LEN_W'(MAX_PATTERN);
        else
            active_len = LEN_W'(pattern_length_reg);
    end

    always_comb
    begin
        bytes_equal = 1'b1;
        pidx        = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pidx = active_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < active_len &&
                window_next[j] != pattern_bytes[pidx[IDX_W-1:0]])
                bytes_equal = 1'b0;
        end
    end

    assign fill_next     = (fill_reg < LEN_W'(MAX_PATTERN)) ? fill_reg + LEN_W'(1) : fill_reg;
    assign position_next = (position_reg < POS_SAT) ? position_reg + POS_W'(1) : position_reg;

    assign begin_pos = position_reg + POS_W'(1) - POS_W'(active_len);
    assign begin_ext = CMP_W'(begin_pos);
    assign start_ext = CMP_W'(search_start_reg);
    assign hit       = bytes_equal && (fill_next >= active_len) &&
                       (begin_ext >= start_ext) && !begin_pos[POSITION_BITS];

    assign emit_hit      = !reported_reg && hit;
    assign emit_miss     = !reported_reg && !hit && last_byte_reg;
    assign reported_next = reported_reg || emit_hit;

    assign fire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign data.ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (data.ready)
            in_valid_reg <= data.valid;
    end

    always_ff @(posedge clk)
    begin
        if (data.ready && data.valid)
        begin
            data_byte_reg <= data.payload.data_byte;
            last_byte_reg <= data.payload.last_byte;
        end
    end

    // view state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            fill_reg     <= '0;
            reported_reg <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++)
                window_reg[j] <= '0;
        end
        else if (fire)
        begin
            if (last_byte_reg)
            begin
                position_reg <= '0;
                fill_reg     <= '0;
                reported_reg <= 1'b0;
                for (int j = 0; j < MAX_PATTERN; j++)
                    window_reg[j] <= '0;
            end
            else
            begin
                position_reg <= position_next;
                fill_reg     <= fill_next;
                reported_reg <= reported_next;
                for (int j = 0; j < MAX_PATTERN; j++)
                    window_reg[j] <= window_next[j];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= emit_hit || emit_miss;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && (emit_hit || emit_miss))
        begin
            found_reg          <= emit_hit;
            match_position_reg <= emit_hit ? begin_ext[MATCH_POS_W-1:0] : '0;
        end
    end

    assign result.valid                  = out_valid_reg;
    assign result.payload.found          = found_reg;
    assign result.payload.match_position = match_position_reg;

    a_view_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte_reg |=> position_reg == '0 && fill_reg == '0 && !reported_reg)
        else $error("view state not cleared after last byte");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_W'(MAX_PATTERN) && POS_W'(fill_reg) <= position_reg)
        else $error("window fill out of range");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> match_position_reg == '0)
        else $error("not-found result carries a position");

    a_single_report: assert property (@(posedge clk) disable iff (!rst_n)
        fire && reported_reg |=> !out_valid_reg || $stable(match_position_reg))
        else $error("second result in one view");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for substring_first_match_core
// depends on sfm_pkg, sfm_stream_if and the core; a scoreboard class predicts per view
// byte stream the first-match reports and checks every result transfer against them

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    localparam int          WINDOW_DEPTH = 16;
    localparam int          POS_BITS     = 16;
    localparam int unsigned POS_LIMIT    = 1 << POS_BITS;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          IDLE_ITEMS   = 880;
    localparam int          RANDOM_ITEMS = 1000;

    class search_scoreboard;
        logic [63:0]          pattern_lo;
        logic [63:0]          pattern_hi;
        logic [4:0]           pattern_len;
        logic [15:0]          start_pos;
        logic [7:0]           window [WINDOW_DEPTH];
        int unsigned          view_pos;
        int unsigned          fill;
        bit                   reported;
        out_item_t            pending_results [$];
        int unsigned          errors;

        function new();
            pattern_lo  = '0;
            pattern_hi  = '0;
            pattern_len = 5'd1;
            start_pos   = '0;
            errors      = 0;
            clear_view();
        endfunction

        function void clear_view();
            foreach (window[i]) window[i] = '0;
            view_pos = 0;
            fill     = 0;
            reported = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PATTERN_LOW:    pattern_lo  = value;
                CFG_PATTERN_HIGH:   pattern_hi  = value;
                CFG_PATTERN_LENGTH: pattern_len = value[4:0];
                CFG_SEARCH_START:   start_pos   = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_byte(int i);
            if (i < 8)
                return pattern_lo[8*i +: 8];
            return pattern_hi[8*(i-8) +: 8];
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int          len;
            int unsigned pos;
            int unsigned first;
            bit          hit;
            out_item_t   exp_item;
            len = pattern_len;
            if (len == 0)
                len = 1;
            if (len > WINDOW_DEPTH)
                len = WINDOW_DEPTH;
            pos = view_pos;
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            if (fill < WINDOW_DEPTH)
                fill++;
            if (view_pos < POS_LIMIT + WINDOW_DEPTH)
                view_pos++;
            if (!reported && fill >= len)
            begin
                first = pos + 1 - len;
                hit = (first >= start_pos) && (first < POS_LIMIT);
                for (int i = 0; i < len; i++)
                    if (window[len-1-i] != pattern_byte(i))
                        hit = 0;
                if (hit)
                begin
                    reported = 1;
                    exp_item.found = 1'b1;
                    exp_item.match_position = first[15:0];
                    pending_results.push_back(exp_item);
                end
            end
            if (last)
            begin
                if (!reported)
                begin
                    exp_item.found = 1'b0;
                    exp_item.match_position = '0;
                    pending_results.push_back(exp_item);
                end
                clear_view();
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_item;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result found %0d position %0d",
                         $time, got.found, got.match_position);
                errors++;
                return;
            end
            exp_item = pending_results.pop_front();
            if (got.found !== exp_item.found)
            begin
                $display("%0t: found expected %0d actual %0d",
                         $time, exp_item.found, got.found);
                errors++;
            end
            if (got.match_position !== exp_item.match_position)
            begin
                $display("%0t: match_position expected %0d actual %0d",
                         $time, exp_item.match_position, got.match_position);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_write_data;

    sfm_stream_if #(.payload_t(in_item_t))  byte_ch ();
    sfm_stream_if #(.payload_t(out_item_t)) result_ch ();

    substring_first_match_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .data           (byte_ch),
        .result         (result_ch)
    );

    search_scoreboard sb;
    logic [7:0]       view_bytes [$];
    bit               src_idle_en;
    bit               sink_idle_en;
    int unsigned      random_sent;
    int unsigned      cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[substring_first_match_core] ERROR");
        $finish;
    end

    // result sink with random stall bursts
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            result_ch.ready = 1'b1;
        end
    end

    // results are checked before the byte of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.payload);
            if (byte_ch.valid && byte_ch.ready)
                sb.note_byte(byte_ch.payload.data_byte, byte_ch.payload.last_byte);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write_en   = 1'b1;
        cfg_index      = idx;
        cfg_write_data = value;
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        byte_ch.valid             = 1'b1;
        byte_ch.payload.data_byte = b;
        byte_ch.payload.last_byte = last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_view();
        for (int i = 0; i < view_bytes.size(); i++)
            send_byte(view_bytes[i], i == view_bytes.size() - 1);
    endtask

    task automatic wait_idle();
        byte_ch.valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte(int n_alpha, logic [7:0] alpha [4]);
        if (n_alpha == 0)
            return 8'($urandom);
        return alpha[$urandom_range(0, n_alpha - 1)];
    endfunction

    task automatic random_phase(input bit idle_ok);
        logic [7:0]  alpha [4];
        logic [7:0]  pat [16];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;
        int          n_alpha;
        int          len_raw;
        int          eff_len;
        int          kind;
        int          vlen;
        int          at;
        int          view_alpha;
        for (int i = 0; i < 4; i++)
            alpha[i] = 8'($urandom);
        n_alpha = $urandom_range(0, 4);
        for (int i = 0; i < 16; i++)
            pat[i] = pick_byte(n_alpha, alpha);
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = pat[i];
            hi[8*i +: 8] = pat[i+8];
        end
        len_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        eff_len = (len_raw == 0) ? 1 : (len_raw > 16) ? 16 : len_raw;
        len_word = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            len_word = '0;
        len_word[4:0] = 5'(len_raw);
        kind = $urandom_range(0, 9);
        src_idle_en  = idle_ok && ($urandom_range(0, 3) != 0);
        sink_idle_en = idle_ok && ($urandom_range(0, 3) != 0);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, len_word);
        if (kind < 6)
            write_reg(CFG_SEARCH_START, 64'($urandom_range(0, 12)));
        else if (kind < 9)
            write_reg(CFG_SEARCH_START, '0);
        else
            write_reg(CFG_SEARCH_START, {$urandom, $urandom});
        repeat ($urandom_range(2, 8))
        begin
            vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 80) : $urandom_range(1, 40);
            view_alpha = ($urandom_range(0, 4) == 0) ? 0 : n_alpha;
            view_bytes.delete();
            for (int i = 0; i < vlen; i++)
                view_bytes.push_back(pick_byte(view_alpha, alpha));
            if ($urandom_range(0, 2) != 0 && vlen >= eff_len)
            begin
                at = $urandom_range(0, vlen - eff_len);
                for (int i = 0; i < eff_len; i++)
                    view_bytes[at+i] = pat[i];
                // broken copy of the pattern
                if ($urandom_range(0, 5) == 0)
                    view_bytes[at + $urandom_range(0, eff_len - 1)] ^= 8'h01 << $urandom_range(0, 7);
            end
            send_view();
            random_sent += vlen;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_index           = '0;
        cfg_write_data      = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.payload     = '0;
        src_idle_en         = 1'b1;
        sink_idle_en        = 1'b1;
        random_sent         = 0;
        sb                  = new();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset configuration: single zero byte, match on the last byte
        view_bytes = '{8'h00};
        send_view();
        view_bytes = '{8'h7F, 8'h80, 8'hFF};
        send_view();
        wait_idle();

        // zero length acts as one
        write_reg(CFG_PATTERN_LENGTH, '0);
        write_reg(CFG_PATTERN_LOW, 64'hFF);
        view_bytes = '{8'h01, 8'hFF, 8'h00};
        send_view();
        wait_idle();

        // oversized length saturates to 16, full pattern ends on the last byte
        write_reg(CFG_PATTERN_LOW, {$urandom, $urandom});
        write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
        write_reg(CFG_PATTERN_LENGTH, {$urandom, 27'h0, 5'd31});
        write_reg(CFG_SEARCH_START, '0);
        view_bytes.delete();
        for (int i = 0; i < 16; i++)
            view_bytes.push_back(sb.pattern_byte(i));
        send_view();
        wait_idle();

        while (random_sent < IDLE_ITEMS)
            random_phase(1'b1);

        // last part of the run without idling
        while (random_sent < RANDOM_ITEMS)
            random_phase(1'b0);

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("[substring_first_match_core] OK");
        else
            $display("[substring_first_match_core] ERROR");
        $finish;
    end

endmodule

// ----- substring_first_match_core.f -----
rtl/sfm_pkg.sv
rtl/sfm_stream_if.sv
rtl/substring_first_match_core.sv
sim/tb_top.sv
